// ===== sv/ssudp_pkg.sv =====
// shared types and constants for the ssu data payload parser
// no dependencies; used by every module of the block
`default_nettype none

package ssudp_pkg;

    typedef enum logic [3:0] {
        PH_FLAG      = 4'd0,
        PH_ACK_CNT   = 4'd1,
        PH_ACK_ID    = 4'd2,
        PH_BF_CNT    = 4'd3,
        PH_BF_ID     = 4'd4,
        PH_BF_BYTE   = 4'd5,
        PH_EXT_SIZE  = 4'd6,
        PH_EXT_SKIP  = 4'd7,
        PH_FRAG_CNT  = 4'd8,
        PH_FRAG_ID   = 4'd9,
        PH_FRAG_INFO = 4'd10,
        PH_FRAG_DATA = 4'd11,
        PH_DONE      = 4'd12
    } phase_t;

    // result kinds
    localparam logic [2:0] KIND_ACK      = 3'd0;
    localparam logic [2:0] KIND_BITFIELD = 3'd1;
    localparam logic [2:0] KIND_FRAG_HDR = 3'd2;
    localparam logic [2:0] KIND_PAYLOAD  = 3'd3;
    localparam logic [2:0] KIND_END      = 3'd4;

    // packet end status
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd1;
    localparam logic [1:0] STATUS_OVERSIZE  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_EXPLICIT_ACK = 2'd0;
    localparam logic [1:0] CFG_BITFIELD_ACK = 2'd1;
    localparam logic [1:0] CFG_EXT_DATA     = 2'd2;
    localparam logic [1:0] CFG_MAX_FRAG     = 2'd3;

    localparam int CFG_DATA_W = 14;
    localparam int TDATA_W    = 72;

    typedef struct packed {
        logic [7:0]  explicit_ack_flag_mask;
        logic [7:0]  bitfield_ack_flag_mask;
        logic [7:0]  extended_data_flag_mask;
        logic [13:0] max_fragment_size;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] msg_id;
        logic [6:0]  frag_base;
        logic [6:0]  ack_mask;
        logic [13:0] frag_size;
        logic        frag_last;
        logic [7:0]  data_byte;
        logic [1:0]  end_status;
        logic        run_last;
    } res_t;

endpackage

`default_nettype wire

// ===== sv/ssu_data_payload_parser.sv =====
// top level of the ssu data payload parser: config registers, input register,
// parser and result queue; depends on ssudp_pkg, ssudp_parser, ssudp_res_fifo
//
//  channel   dir  handshake             payload
//  s_*       in   s_tvalid / s_tready   tdata = in_byte, tlast = last_byte
//  m_*       out  m_tvalid / m_tready   tdata = result fields, tuser = kind,
//                                       tlast = run_last
//  cfg_*     in   cfg_we                cfg_addr = register index, cfg_data
//
// one byte enters per cycle while s_tready is high; it is held in the input
// register, and when the parser steps, its results land in the four-entry
// result queue, which hands them out one at a time, so the data result and
// packet end of one byte leave in turn. s_tready drops when the input
// register is full and the queue has fewer than two free slots. reset
// returns the parser to expecting a flag byte and loads the register defaults.
`default_nettype none

module ssu_data_payload_parser (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [7:0]                          s_tdata,  // in_byte
    input  wire logic                                s_tlast,  // last_byte
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // msg_id[31:0], frag_base[38:32], ack_mask[45:39], frag_size[59:46],
    // frag_last[60], data_byte[68:61], end_status[70:69], zero[71]
    output logic [ssudp_pkg::TDATA_W-1:0]            m_tdata,
    output logic [2:0]                               m_tuser,  // kind
    output logic                                     m_tlast,  // run_last
    input  wire logic                                cfg_we,
    input  wire logic [1:0]                          cfg_addr,
    input  wire logic [ssudp_pkg::CFG_DATA_W-1:0]    cfg_data
);

    ssudp_pkg::cfg_t cfg_reg;
    logic            in_vld_reg, in_vld_next;
    logic [7:0]      in_byte_reg;
    logic            in_last_reg;
    logic            s_accept;
    logic            advance;
    logic            room2;

    ssudp_pkg::res_t r0, r1, head;
    logic            r0_vld, r1_vld;

    assign advance  = in_vld_reg && room2;
    assign s_tready = !in_vld_reg || room2;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        if (s_accept)
            in_vld_next = 1'b1;
        else if (advance)
            in_vld_next = 1'b0;
        else
            in_vld_next = in_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg                      <= 1'b0;
            cfg_reg.explicit_ack_flag_mask  <= 8'h80;
            cfg_reg.bitfield_ack_flag_mask  <= 8'h40;
            cfg_reg.extended_data_flag_mask <= 8'h02;
            cfg_reg.max_fragment_size       <= 14'd1484;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    ssudp_pkg::CFG_EXPLICIT_ACK:
                        cfg_reg.explicit_ack_flag_mask <= cfg_data[7:0];
                    ssudp_pkg::CFG_BITFIELD_ACK:
                        cfg_reg.bitfield_ack_flag_mask <= cfg_data[7:0];
                    ssudp_pkg::CFG_EXT_DATA:
                        cfg_reg.extended_data_flag_mask <= cfg_data[7:0];
                    ssudp_pkg::CFG_MAX_FRAG:
                        cfg_reg.max_fragment_size <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    ssudp_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .in_byte  (in_byte_reg),
        .in_last  (in_last_reg),
        .cfg      (cfg_reg),
        .out0     (r0),
        .out0_vld (r0_vld),
        .out1     (r1),
        .out1_vld (r1_vld)
    );

    ssudp_res_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push0_data (r0),
        .push0      (r0_vld),
        .push1_data (r1),
        .push1      (r1_vld),
        .room2      (room2),
        .head       (head),
        .head_vld   (m_tvalid),
        .pop        (m_tready)
    );

    assign m_tdata = {1'b0, head.end_status, head.data_byte, head.frag_last,
                      head.frag_size, head.ack_mask, head.frag_base, head.msg_id};
    assign m_tuser = head.kind;
    assign m_tlast = head.run_last;

endmodule

`default_nettype wire

// ===== sv/ssudp_parser.sv =====
// byte-serial parse state and next-state logic, up to two results per byte
// depends on ssudp_pkg
`default_nettype none

module ssudp_parser (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [7:0]        in_byte,
    input  wire logic              in_last,
    input  wire ssudp_pkg::cfg_t   cfg,
    output ssudp_pkg::res_t        out0,
    output logic                   out0_vld,
    output ssudp_pkg::res_t        out1,
    output logic                   out1_vld
);

    ssudp_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  flag_reg, flag_next;
    logic [7:0]  items_reg, items_next;
    logic [13:0] cnt_reg, cnt_next;
    logic [31:0] id_reg, id_next;
    logic [23:0] info_reg, info_next;
    logic [6:0]  base_reg, base_next;
    logic        abort_reg, abort_next;

    ssudp_pkg::res_t r0;
    ssudp_pkg::res_t r_end;
    logic            r0_vld;
    logic [13:0]     cnt_inc;
    logic [13:0]     cnt_dec;
    logic [7:0]      items_dec;
    logic [31:0]     id_shifted;
    logic [23:0]     info_shifted;
    logic [13:0]     size;

    // first present section after the given stage
    function automatic ssudp_pkg::phase_t next_sec(input logic [1:0] stage,
                                                   input logic [7:0] flag,
                                                   input ssudp_pkg::cfg_t c);
        ssudp_pkg::phase_t ph;
        begin
            if (stage < 2'd1 && (flag & c.explicit_ack_flag_mask) != 8'd0)
                ph = ssudp_pkg::PH_ACK_CNT;
            else if (stage < 2'd2 && (flag & c.bitfield_ack_flag_mask) != 8'd0)
                ph = ssudp_pkg::PH_BF_CNT;
            else if (stage < 2'd3 && (flag & c.extended_data_flag_mask) != 8'd0)
                ph = ssudp_pkg::PH_EXT_SIZE;
            else
                ph = ssudp_pkg::PH_FRAG_CNT;
            return ph;
        end
    endfunction

    always_comb
    begin
        phase_next = phase_reg;
        flag_next  = flag_reg;
        items_next = items_reg;
        cnt_next   = cnt_reg;
        id_next    = id_reg;
        info_next  = info_reg;
        base_next  = base_reg;
        abort_next = abort_reg;
        r0         = '0;
        r0_vld     = 1'b0;
        r_end      = '0;

        cnt_inc      = cnt_reg + 14'd1;
        cnt_dec      = cnt_reg - 14'd1;
        items_dec    = items_reg - 8'd1;
        id_shifted   = {id_reg[23:0], in_byte};
        info_shifted = {info_reg[15:0], in_byte};
        size         = info_shifted[13:0];

        unique case (phase_reg)
            ssudp_pkg::PH_FLAG:
            begin
                flag_next  = in_byte;
                cnt_next   = '0;
                phase_next = next_sec(2'd0, in_byte, cfg);
            end
            ssudp_pkg::PH_ACK_CNT:
            begin
                items_next = in_byte;
                cnt_next   = '0;
                if (in_byte == 8'd0)
                    phase_next = next_sec(2'd1, flag_reg, cfg);
                else
                    phase_next = ssudp_pkg::PH_ACK_ID;
            end
            ssudp_pkg::PH_ACK_ID:
            begin
                id_next  = id_shifted;
                cnt_next = cnt_inc;
                if (cnt_inc >= 14'd4)
                begin
                    r0_vld     = 1'b1;
                    r0.kind    = ssudp_pkg::KIND_ACK;
                    r0.msg_id  = id_shifted;
                    cnt_next   = '0;
                    items_next = items_dec;
                    if (items_dec == 8'd0)
                        phase_next = next_sec(2'd1, flag_reg, cfg);
                end
            end
            ssudp_pkg::PH_BF_CNT:
            begin
                items_next = in_byte;
                cnt_next   = '0;
                if (in_byte == 8'd0)
                    phase_next = next_sec(2'd2, flag_reg, cfg);
                else
                    phase_next = ssudp_pkg::PH_BF_ID;
            end
            ssudp_pkg::PH_BF_ID:
            begin
                id_next  = id_shifted;
                cnt_next = cnt_inc;
                if (cnt_inc >= 14'd4)
                begin
                    cnt_next   = '0;
                    base_next  = '0;
                    phase_next = ssudp_pkg::PH_BF_BYTE;
                end
            end
            ssudp_pkg::PH_BF_BYTE:
            begin
                r0_vld       = 1'b1;
                r0.kind      = ssudp_pkg::KIND_BITFIELD;
                r0.msg_id    = id_reg;
                r0.frag_base = base_reg;
                r0.ack_mask  = in_byte[6:0];
                // base moves on by seven per byte, held at 127
                base_next = (base_reg >= 7'd120) ? 7'd127 : base_reg + 7'd7;
                if (!in_byte[7])
                begin
                    items_next = items_dec;
                    if (items_dec == 8'd0)
                        phase_next = next_sec(2'd2, flag_reg, cfg);
                    else
                        phase_next = ssudp_pkg::PH_BF_ID;
                end
            end
            ssudp_pkg::PH_EXT_SIZE:
            begin
                cnt_next   = {6'd0, in_byte};
                phase_next = (in_byte == 8'd0) ? ssudp_pkg::PH_FRAG_CNT
                                               : ssudp_pkg::PH_EXT_SKIP;
            end
            ssudp_pkg::PH_EXT_SKIP:
            begin
                cnt_next = cnt_dec;
                if (cnt_dec == 14'd0)
                    phase_next = ssudp_pkg::PH_FRAG_CNT;
            end
            ssudp_pkg::PH_FRAG_CNT:
            begin
                items_next = in_byte;
                cnt_next   = '0;
                phase_next = (in_byte == 8'd0) ? ssudp_pkg::PH_DONE
                                               : ssudp_pkg::PH_FRAG_ID;
            end
            ssudp_pkg::PH_FRAG_ID:
            begin
                id_next  = id_shifted;
                cnt_next = cnt_inc;
                if (cnt_inc >= 14'd4)
                begin
                    cnt_next   = '0;
                    info_next  = '0;
                    phase_next = ssudp_pkg::PH_FRAG_INFO;
                end
            end
            ssudp_pkg::PH_FRAG_INFO:
            begin
                info_next = info_shifted;
                cnt_next  = cnt_inc;
                if (cnt_inc >= 14'd3)
                begin
                    if (size >= cfg.max_fragment_size)
                    begin
                        abort_next = 1'b1;
                        cnt_next   = '0;
                        phase_next = ssudp_pkg::PH_DONE;
                    end
                    else
                    begin
                        r0_vld       = 1'b1;
                        r0.kind      = ssudp_pkg::KIND_FRAG_HDR;
                        r0.msg_id    = id_reg;
                        r0.frag_base = info_shifted[23:17];
                        r0.frag_size = size;
                        r0.frag_last = info_shifted[16];
                        cnt_next     = size;
                        if (size == 14'd0)
                        begin
                            items_next = items_dec;
                            cnt_next   = '0;
                            phase_next = (items_dec == 8'd0) ? ssudp_pkg::PH_DONE
                                                             : ssudp_pkg::PH_FRAG_ID;
                        end
                        else
                            phase_next = ssudp_pkg::PH_FRAG_DATA;
                    end
                end
            end
            ssudp_pkg::PH_FRAG_DATA:
            begin
                r0_vld       = 1'b1;
                r0.kind      = ssudp_pkg::KIND_PAYLOAD;
                r0.data_byte = in_byte;
                cnt_next     = cnt_dec;
                if (cnt_dec == 14'd0)
                begin
                    items_next = items_dec;
                    phase_next = (items_dec == 8'd0) ? ssudp_pkg::PH_DONE
                                                     : ssudp_pkg::PH_FRAG_ID;
                end
            end
            default:
            begin
                // done, or a code with no meaning: bytes are ignored
            end
        endcase

        r_end.kind = ssudp_pkg::KIND_END;
        if (abort_next)
            r_end.end_status = ssudp_pkg::STATUS_OVERSIZE;
        else if (phase_next == ssudp_pkg::PH_DONE)
            r_end.end_status = ssudp_pkg::STATUS_OK;
        else
            r_end.end_status = ssudp_pkg::STATUS_TRUNCATED;
        r_end.run_last = 1'b1;

        if (in_last)
        begin
            phase_next = ssudp_pkg::PH_FLAG;
            flag_next  = '0;
            items_next = '0;
            cnt_next   = '0;
            id_next    = '0;
            info_next  = '0;
            base_next  = '0;
            abort_next = 1'b0;
        end

        // pack the results so the first present one leads
        if (r0_vld)
        begin
            out0          = r0;
            out0.run_last = !in_last;
            out0_vld      = step;
            out1          = r_end;
            out1_vld      = step && in_last;
        end
        else
        begin
            out0     = r_end;
            out0_vld = step && in_last;
            out1     = r_end;
            out1_vld = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ssudp_pkg::PH_FLAG;
            flag_reg  <= '0;
            items_reg <= '0;
            cnt_reg   <= '0;
            id_reg    <= '0;
            info_reg  <= '0;
            base_reg  <= '0;
            abort_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            flag_reg  <= flag_next;
            items_reg <= items_next;
            cnt_reg   <= cnt_next;
            id_reg    <= id_next;
            info_reg  <= info_next;
            base_reg  <= base_next;
            abort_reg <= abort_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/ssudp_res_fifo.sv =====
// four-entry result queue taking up to two results per cycle, one out per cycle
// depends on ssudp_pkg
`default_nettype none

module ssudp_res_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire ssudp_pkg::res_t push0_data,
    input  wire logic            push0,
    input  wire ssudp_pkg::res_t push1_data,
    input  wire logic            push1,
    output logic                 room2,
    output ssudp_pkg::res_t      head,
    output logic                 head_vld,
    input  wire logic            pop
);

    ssudp_pkg::res_t mem_reg [4];
    logic [1:0] wr_reg, wr_next;
    logic [1:0] rd_reg, rd_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       do_pop;

    assign head_vld = (cnt_reg != 3'd0);
    assign head     = mem_reg[rd_reg];
    assign room2    = (cnt_reg <= 3'd2);
    assign do_pop   = pop && head_vld;

    always_comb
    begin
        wr_next  = wr_reg + {1'b0, push0} + {1'b0, push1};
        rd_next  = rd_reg + {1'b0, do_pop};
        cnt_next = cnt_reg + {2'd0, push0} + {2'd0, push1} - {2'd0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push0)
            mem_reg[wr_reg] <= push0_data;
        if (push1)
            mem_reg[wr_reg + 2'd1] <= push1_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// testbench for ssu_data_payload_parser: random and directed payload packets,
// a scoreboard that predicts every result item, and random stalls on both sides
// depends on ssudp_pkg and the ssu_data_payload_parser rtl
module tb_top;

    localparam int CYCLE_LIMIT = 1_000_000;

    class payload_scoreboard;
        ssudp_pkg::cfg_t   regs;
        ssudp_pkg::phase_t phase;
        logic [7:0]        flags;
        logic [7:0]        remaining;
        logic [13:0]       countdown;
        logic [31:0]       id_acc;
        logic [23:0]       info_acc;
        logic [6:0]        base;
        logic              aborted;
        ssudp_pkg::res_t   step_out[$];
        ssudp_pkg::res_t   pending_results[$];
        int                errors;

        function new();
            regs.explicit_ack_flag_mask  = 8'h80;
            regs.bitfield_ack_flag_mask  = 8'h40;
            regs.extended_data_flag_mask = 8'h02;
            regs.max_fragment_size       = 14'd1484;
            errors = 0;
            clear_packet();
        endfunction

        function void set_register(logic [1:0] idx, logic [13:0] value);
            case (idx)
                ssudp_pkg::CFG_EXPLICIT_ACK: regs.explicit_ack_flag_mask = value[7:0];
                ssudp_pkg::CFG_BITFIELD_ACK: regs.bitfield_ack_flag_mask = value[7:0];
                ssudp_pkg::CFG_EXT_DATA:     regs.extended_data_flag_mask = value[7:0];
                ssudp_pkg::CFG_MAX_FRAG:     regs.max_fragment_size = value;
                default: ;
            endcase
        endfunction

        function void clear_packet();
            phase     = ssudp_pkg::PH_FLAG;
            flags     = '0;
            remaining = '0;
            countdown = '0;
            id_acc    = '0;
            info_acc  = '0;
            base      = '0;
            aborted   = 1'b0;
        endfunction

        // stage: 0 after flag, 1 after explicit acks, 2 after bitfields
        function void enter_section(int stage);
            countdown = '0;
            if (stage < 1 && (flags & regs.explicit_ack_flag_mask) != 0)
                phase = ssudp_pkg::PH_ACK_CNT;
            else if (stage < 2 && (flags & regs.bitfield_ack_flag_mask) != 0)
                phase = ssudp_pkg::PH_BF_CNT;
            else if ((flags & regs.extended_data_flag_mask) != 0)
                phase = ssudp_pkg::PH_EXT_SIZE;
            else
                phase = ssudp_pkg::PH_FRAG_CNT;
        endfunction

        function void finish_fragment();
            remaining--;
            countdown = '0;
            phase = (remaining == 0) ? ssudp_pkg::PH_DONE : ssudp_pkg::PH_FRAG_ID;
        endfunction

        function void add_result(logic [2:0] kind, logic [31:0] id, logic [6:0] fbase,
                                 logic [6:0] mask, logic [13:0] size, logic flast,
                                 logic [7:0] data, logic [1:0] status);
            ssudp_pkg::res_t r;
            r.kind       = kind;
            r.msg_id     = id;
            r.frag_base  = fbase;
            r.ack_mask   = mask;
            r.frag_size  = size;
            r.frag_last  = flast;
            r.data_byte  = data;
            r.end_status = status;
            r.run_last   = 1'b0;
            step_out.insert(step_out.size(), r);
        endfunction

        function void parse_byte(logic [7:0] b, logic last);
            ssudp_pkg::res_t r;
            logic [13:0]     size;
            logic [1:0]      status;
            step_out.delete();
            case (phase)
                ssudp_pkg::PH_FLAG:
                begin
                    flags = b;
                    enter_section(0);
                end
                ssudp_pkg::PH_ACK_CNT:
                begin
                    remaining = b;
                    countdown = '0;
                    if (b == 0) enter_section(1);
                    else phase = ssudp_pkg::PH_ACK_ID;
                end
                ssudp_pkg::PH_ACK_ID:
                begin
                    id_acc = {id_acc[23:0], b};
                    countdown++;
                    if (countdown >= 4)
                    begin
                        add_result(ssudp_pkg::KIND_ACK, id_acc, '0, '0, '0, 1'b0, '0,
                                   ssudp_pkg::STATUS_OK);
                        countdown = '0;
                        remaining--;
                        if (remaining == 0) enter_section(1);
                    end
                end
                ssudp_pkg::PH_BF_CNT:
                begin
                    remaining = b;
                    countdown = '0;
                    if (b == 0) enter_section(2);
                    else phase = ssudp_pkg::PH_BF_ID;
                end
                ssudp_pkg::PH_BF_ID:
                begin
                    id_acc = {id_acc[23:0], b};
                    countdown++;
                    if (countdown >= 4)
                    begin
                        countdown = '0;
                        base = '0;
                        phase = ssudp_pkg::PH_BF_BYTE;
                    end
                end
                ssudp_pkg::PH_BF_BYTE:
                begin
                    add_result(ssudp_pkg::KIND_BITFIELD, id_acc, base, b[6:0], '0, 1'b0, '0,
                               ssudp_pkg::STATUS_OK);
                    base = (base >= 7'd120) ? 7'd127 : base + 7'd7;
                    // bit 7 clear ends this entry's chain
                    if (!b[7])
                    begin
                        remaining--;
                        if (remaining == 0) enter_section(2);
                        else phase = ssudp_pkg::PH_BF_ID;
                    end
                end
                ssudp_pkg::PH_EXT_SIZE:
                begin
                    countdown = {6'd0, b};
                    phase = (b == 0) ? ssudp_pkg::PH_FRAG_CNT : ssudp_pkg::PH_EXT_SKIP;
                end
                ssudp_pkg::PH_EXT_SKIP:
                begin
                    countdown--;
                    if (countdown == 0) phase = ssudp_pkg::PH_FRAG_CNT;
                end
                ssudp_pkg::PH_FRAG_CNT:
                begin
                    remaining = b;
                    countdown = '0;
                    phase = (b == 0) ? ssudp_pkg::PH_DONE : ssudp_pkg::PH_FRAG_ID;
                end
                ssudp_pkg::PH_FRAG_ID:
                begin
                    id_acc = {id_acc[23:0], b};
                    countdown++;
                    if (countdown >= 4)
                    begin
                        countdown = '0;
                        info_acc = '0;
                        phase = ssudp_pkg::PH_FRAG_INFO;
                    end
                end
                ssudp_pkg::PH_FRAG_INFO:
                begin
                    info_acc = {info_acc[15:0], b};
                    countdown++;
                    if (countdown >= 3)
                    begin
                        size = info_acc[13:0];
                        if (size >= regs.max_fragment_size)
                        begin
                            aborted = 1'b1;
                            countdown = '0;
                            phase = ssudp_pkg::PH_DONE;
                        end
                        else
                        begin
                            add_result(ssudp_pkg::KIND_FRAG_HDR, id_acc, info_acc[23:17], '0,
                                       size, info_acc[16], '0, ssudp_pkg::STATUS_OK);
                            countdown = size;
                            if (size == 0) finish_fragment();
                            else phase = ssudp_pkg::PH_FRAG_DATA;
                        end
                    end
                end
                ssudp_pkg::PH_FRAG_DATA:
                begin
                    add_result(ssudp_pkg::KIND_PAYLOAD, '0, '0, '0, '0, 1'b0, b,
                               ssudp_pkg::STATUS_OK);
                    countdown--;
                    if (countdown == 0) finish_fragment();
                end
                default: ;
            endcase

            if (last)
            begin
                if (aborted) status = ssudp_pkg::STATUS_OVERSIZE;
                else if (phase == ssudp_pkg::PH_DONE) status = ssudp_pkg::STATUS_OK;
                else status = ssudp_pkg::STATUS_TRUNCATED;
                add_result(ssudp_pkg::KIND_END, '0, '0, '0, '0, 1'b0, '0, status);
                clear_packet();
            end

            if (step_out.size() > 0)
            begin
                r = step_out[step_out.size() - 1];
                r.run_last = 1'b1;
                step_out[step_out.size() - 1] = r;
            end
            foreach (step_out[i]) pending_results.insert(pending_results.size(), step_out[i]);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(ssudp_pkg::res_t got);
            ssudp_pkg::res_t want;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: result item with none expected, kind %0d msg_id %0h",
                         $time, got.kind, got.msg_id);
                return;
            end
            want = pending_results.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("msg_id", want.msg_id, got.msg_id);
            compare_field("frag_base", want.frag_base, got.frag_base);
            compare_field("ack_mask", want.ack_mask, got.ack_mask);
            compare_field("frag_size", want.frag_size, got.frag_size);
            compare_field("frag_last", want.frag_last, got.frag_last);
            compare_field("data_byte", want.data_byte, got.data_byte);
            compare_field("end_status", want.end_status, got.end_status);
            compare_field("run_last", want.run_last, got.run_last);
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [7:0]                       s_tdata = '0;
    logic                             s_tlast = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [ssudp_pkg::TDATA_W-1:0]    m_tdata;
    logic [2:0]                       m_tuser;
    logic                             m_tlast;
    logic                             cfg_we = 1'b0;
    logic [1:0]                       cfg_addr = '0;
    logic [ssudp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    payload_scoreboard sb;
    logic [7:0]        pkt[$];
    int                items_sent;
    bit                sender_steady;
    int                ready_hold;
    int unsigned       cycle_count;

    ssu_data_payload_parser dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // receiver: ready streaks alternate with stalls
    always @(posedge clk)
    begin
        if (ready_hold > 0)
            ready_hold <= ready_hold - 1;
        else if (m_tready)
        begin
            m_tready <= 1'b0;
            ready_hold <= idle_len();
        end
        else
        begin
            m_tready <= 1'b1;
            ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(0, 20);
        end
    end

    always @(posedge clk)
    begin
        ssudp_pkg::res_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind       = m_tuser;
            got.msg_id     = m_tdata[31:0];
            got.frag_base  = m_tdata[38:32];
            got.ack_mask   = m_tdata[45:39];
            got.frag_size  = m_tdata[59:46];
            got.frag_last  = m_tdata[60];
            got.data_byte  = m_tdata[68:61];
            got.end_status = m_tdata[70:69];
            got.run_last   = m_tlast;
            sb.check_result(got);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        sb.parse_byte(b, last);
        items_sent++;
        gap = sender_steady ? 0 : idle_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    task automatic send_packet();
        sender_steady = ($urandom_range(0, 3) == 0);
        foreach (pkt[i])
        begin
            send_byte(pkt[i], i == pkt.size() - 1);
            // occasional hold-off mid packet until the output side has caught up
            if ($urandom_range(0, 299) == 0)
                wait_drained();
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [13:0] value);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        @(posedge clk);
        sb.set_register(idx, value);
    endtask

    task automatic apply_settings(input logic [7:0] ack_m, input logic [7:0] bf_m,
                                  input logic [7:0] ext_m, input logic [13:0] max_size);
        wait_drained();
        // items without results may still be in the input register
        repeat (8) @(posedge clk);
        write_reg(ssudp_pkg::CFG_EXPLICIT_ACK, {6'd0, ack_m});
        write_reg(ssudp_pkg::CFG_BITFIELD_ACK, {6'd0, bf_m});
        write_reg(ssudp_pkg::CFG_EXT_DATA, {6'd0, ext_m});
        write_reg(ssudp_pkg::CFG_MAX_FRAG, max_size);
        cfg_we <= 1'b0;
    endtask

    function automatic void append_byte(input logic [7:0] b);
        pkt.insert(pkt.size(), b);
    endfunction

    function automatic void add_random(int n);
        repeat (n) append_byte(8'($urandom));
    endfunction

    function automatic int pick_count();
        return ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
    endfunction

    function automatic void build_packet();
        logic [7:0]  flag;
        logic [23:0] info;
        int          cnt;
        int          len;
        int          sz;
        int          lim;
        int          cap;
        int          r;
        int          keep;
        pkt.delete();
        if ($urandom_range(0, 99) < 8)
        begin
            add_random($urandom_range(1, 24));
            return;
        end
        flag = 8'($urandom);
        append_byte(flag);
        if ((flag & sb.regs.explicit_ack_flag_mask) != 0)
        begin
            cnt = pick_count();
            append_byte(8'(cnt));
            repeat (cnt) add_random(4);
        end
        if ((flag & sb.regs.bitfield_ack_flag_mask) != 0)
        begin
            cnt = pick_count();
            append_byte(8'(cnt));
            repeat (cnt)
            begin
                add_random(4);
                // long chains may drive the base into saturation
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 22)
                                                   : $urandom_range(1, 3);
                for (int i = 0; i < len; i++)
                    append_byte({i < len - 1, 7'($urandom)});
            end
        end
        if ((flag & sb.regs.extended_data_flag_mask) != 0)
        begin
            sz = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
            append_byte(8'(sz));
            add_random(sz);
        end
        cnt = pick_count();
        append_byte(8'(cnt));
        cap = int'(sb.regs.max_fragment_size) - 1;
        for (int f = 0; f < cnt; f++)
        begin
            add_random(4);
            r = $urandom_range(0, 99);
            if (r < 8)
                sz = $urandom_range(int'(sb.regs.max_fragment_size), 16383);
            else
            begin
                lim = (r < 11) ? 600 : (r < 30) ? 64 : 15;
                if (lim > cap) lim = cap;
                sz = $urandom_range(0, lim);
            end
            info = {7'($urandom), 1'($urandom), 2'($urandom), 14'(sz)};
            append_byte(info[23:16]);
            append_byte(info[15:8]);
            append_byte(info[7:0]);
            if (sz >= int'(sb.regs.max_fragment_size))
            begin
                add_random($urandom_range(0, 3));
                break;
            end
            add_random(sz);
        end
        if ($urandom_range(0, 4) == 0)
            add_random($urandom_range(1, 3));
        // cut short so the packet ends mid-field
        if ($urandom_range(0, 99) < 12)
        begin
            keep = $urandom_range(1, pkt.size());
            while (pkt.size() > keep) void'(pkt.pop_back());
        end
    endfunction

    task automatic run_random(input int n);
        int start;
        start = items_sent;
        while (items_sent - start < n)
        begin
            build_packet();
            send_packet();
        end
    endtask

    initial
    begin
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // empty fragment list, ends cleanly
        pkt = '{8'h00, 8'h00};
        send_packet();
        // flag byte alone: fragment count never arrives
        pkt = '{8'h80};
        send_packet();
        // all-ones fragment info on the final byte: oversize abort
        pkt = '{8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_packet();
        // zero bitfield mask with continuation, skipped extended data,
        // zero-size fragment and a trailing byte
        pkt = '{8'h42, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 8'h7F, 8'h01, 8'hFF,
                8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h55};
        send_packet();

        apply_settings(8'hFF, 8'hFF, 8'hFF, 14'd16383);
        run_random(360);
        apply_settings(8'h00, 8'h00, 8'h00, 14'd16);
        run_random(360);
        apply_settings(8'($urandom), 8'($urandom), 8'($urandom),
                       14'($urandom_range(16, 2000)));
        run_random(360);
        apply_settings(8'h01, 8'h02, 8'h04, 14'd100);
        run_random(360);
        apply_settings(8'h80, 8'h40, 8'h02, 14'd1484);
        run_random(360);

        wait_drained();
        repeat (12) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
